FILE: rtl/page_refault_tracking_table_assert.svh
// Assertion helpers for the page refault tracking table.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef PAGE_REFAULT_TRACKING_TABLE_ASSERT_SVH
`define PAGE_REFAULT_TRACKING_TABLE_ASSERT_SVH

// Same-cycle implication.
`define PRT_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/prt_pkg.sv
package prt_pkg;

	// Input opcodes
	typedef enum logic [1:0] {
		OP_EVICT   = 2'd0,
		OP_REFAULT = 2'd1,
		OP_CHECK   = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	// Command class decided at the front
	typedef enum logic [1:0] {
		KIND_IGNORE = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_TICK   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		op_t         op;
		logic [31:0] key;
		logic [31:0] off;
	} cmd_t;

	// Command queue depth (power of two)
	localparam int QDEPTH = 2;

	// Refault count saturation value
	localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage

FILE: rtl/prt_front.sv
module prt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          opcode,
	input  logic [31:0]         file_key,
	input  logic [31:0]         page_offset,
	input  logic                hold,
	output logic                cmd_valid,
	output prt_pkg::cmd_t       cmd,
	input  logic                cmd_pop
);

	localparam int QAW = $clog2(prt_pkg::QDEPTH);

	prt_pkg::cmd_t  q_mem [prt_pkg::QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0]   cnt_q;
	prt_pkg::cmd_t  new_cmd;
	logic           wr;

	// Classify the incoming beat
	always_comb begin
		new_cmd.op  = prt_pkg::op_t'(opcode);
		new_cmd.key = file_key;
		new_cmd.off = page_offset;
		if (prt_pkg::op_t'(opcode) == prt_pkg::OP_TICK) begin
			new_cmd.kind = prt_pkg::KIND_TICK;
		end else if (file_key == 32'd0) begin
			new_cmd.kind = prt_pkg::KIND_IGNORE;
		end else begin
			new_cmd.kind = prt_pkg::KIND_LOOKUP;
		end
	end

	assign full      = (cnt_q == (QAW+1)'(prt_pkg::QDEPTH)) || hold;
	assign wr        = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_mem[rp_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr) begin
			q_mem[wp_q] <= new_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (cmd_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(wr) - (QAW+1)'(cmd_pop);
		end
	end

endmodule

FILE: rtl/prt_engine.sv
module prt_engine #(
	parameter int FILE_SLOTS = 128,
	parameter int PAGE_SLOTS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  prt_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          clearing,
	output logic          empty,
	input  logic          pop,
	output logic          hit,
	output logic [15:0]   refault_count,
	output logic          inserted,
	output logic          table_full,
	output logic [7:0]    files_tracked,
	output logic [10:0]   pages_tracked
);

	`include "page_refault_tracking_table_assert.svh"

	localparam int FW    = $clog2(FILE_SLOTS);
	localparam int PW    = $clog2(PAGE_SLOTS);
	localparam int FCW   = $clog2(FILE_SLOTS + 1);
	localparam int PCW   = $clog2(PAGE_SLOTS + 1);
	localparam int CLR_N = (FILE_SLOTS > PAGE_SLOTS) ? FILE_SLOTS : PAGE_SLOTS;
	localparam int CW    = $clog2(CLR_N);
	localparam int SW    = ((FW > PW) ? FW : PW) + 1;

	typedef struct packed {
		logic        valid;
		logic        mark;
		logic [31:0] id;
	} fent_t;

	typedef struct packed {
		logic          valid;
		logic          mark;
		logic [FW-1:0] owner;
		logic [31:0]   idx;
		logic [15:0]   cnt;
	} pent_t;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_FSCAN = 8'b0000_0100,
		ST_PSCAN = 8'b0000_1000,
		ST_APPLY = 8'b0001_0000,
		ST_AGEP  = 8'b0010_0000,
		ST_AGEF  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  clr_q;
	logic [SW-1:0]  scan_q, raddr_s1;
	logic           rvld_s1;
	prt_pkg::cmd_t  cmd_q;

	logic           ff_q, ffr_q, ph_q, pfr_q;
	logic [FW-1:0]  fidx_q, ffree_q;
	logic [PW-1:0]  pidx_q, pfree_q;
	logic [15:0]    pcnt_q;
	logic [FCW-1:0] live_f_q;
	logic [PCW-1:0] live_p_q;
	logic [FILE_SLOTS-1:0] surv_q;

	logic           out_vld_q, hit_q, ins_q, full_q;
	logic [15:0]    cnt_q;
	logic [7:0]     files_q;
	logic [10:0]    pages_q;

	fent_t          fmem [FILE_SLOTS];
	pent_t          pmem [PAGE_SLOTS];
	fent_t          f_rd_s1, f_wd;
	pent_t          p_rd_s1, p_wd;
	logic           f_we, p_we;
	logic [FW-1:0]  f_wa;
	logic [PW-1:0]  p_wa;

	logic           can_emit, f_issue, p_issue, f_last, p_last;
	logic           do_ins, ins_newf, ins_known, drop, apply_go;
	logic [15:0]    new_cnt;
	logic           f_match, p_match, age_rm_f;

	// Memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[f_wa] <= f_wd;
		end
		f_rd_s1 <= fmem[scan_q[FW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pmem[p_wa] <= p_wd;
		end
		p_rd_s1 <= pmem[scan_q[PW-1:0]];
	end

	// Handshake and scan bookkeeping
	assign can_emit = !out_vld_q || pop;
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign clearing = (state_q == ST_CLEAR);
	assign f_issue  = 32'(scan_q) < FILE_SLOTS;
	assign p_issue  = 32'(scan_q) < PAGE_SLOTS;
	assign f_last   = rvld_s1 && (raddr_s1 == SW'(FILE_SLOTS - 1));
	assign p_last   = rvld_s1 && (raddr_s1 == SW'(PAGE_SLOTS - 1));

	// Scan compares
	assign f_match  = rvld_s1 && f_rd_s1.valid && (f_rd_s1.id == cmd_q.key);
	assign p_match  = rvld_s1 && p_rd_s1.valid && ff_q && (p_rd_s1.owner == fidx_q)
	                  && (p_rd_s1.idx == cmd_q.off);
	assign age_rm_f = !f_rd_s1.mark && !surv_q[raddr_s1[FW-1:0]];

	// Outcome of a lookup
	assign apply_go  = (state_q == ST_APPLY) && can_emit;
	assign ins_newf  = !ph_q && (cmd_q.op != prt_pkg::OP_CHECK) && !ff_q && ffr_q && pfr_q;
	assign ins_known = !ph_q && (cmd_q.op != prt_pkg::OP_CHECK) && ff_q && pfr_q;
	assign do_ins    = ins_newf || ins_known;
	assign drop      = !ph_q && (cmd_q.op != prt_pkg::OP_CHECK) && !do_ins;
	assign new_cnt   = ((cmd_q.op != prt_pkg::OP_EVICT) && (pcnt_q != prt_pkg::CNT_MAX))
	                   ? pcnt_q + 16'd1 : pcnt_q;

	// Write port control
	always_comb begin
		f_we = 1'b0;
		f_wa = '0;
		f_wd = '0;
		p_we = 1'b0;
		p_wa = '0;
		p_wd = '0;
		case (state_q)
			ST_CLEAR: begin
				f_we = 32'(clr_q) < FILE_SLOTS;
				f_wa = clr_q[FW-1:0];
				p_we = 32'(clr_q) < PAGE_SLOTS;
				p_wa = clr_q[PW-1:0];
			end
			ST_APPLY: begin
				f_we     = apply_go && (ff_q || ins_newf);
				f_wa     = ff_q ? fidx_q : ffree_q;
				f_wd     = '{valid: 1'b1, mark: 1'b1, id: cmd_q.key};
				p_we     = apply_go && (ph_q || do_ins);
				p_wa     = ph_q ? pidx_q : pfree_q;
				p_wd     = '{valid: 1'b1, mark: 1'b1, owner: (ff_q ? fidx_q : ffree_q),
				             idx: cmd_q.off, cnt: (ph_q ? new_cnt : 16'd0)};
			end
			ST_AGEP: begin
				p_we       = rvld_s1 && p_rd_s1.valid;
				p_wa       = raddr_s1[PW-1:0];
				p_wd       = p_rd_s1;
				p_wd.mark  = 1'b0;
				p_wd.valid = p_rd_s1.mark;
			end
			ST_AGEF: begin
				f_we       = rvld_s1 && f_rd_s1.valid;
				f_wa       = raddr_s1[FW-1:0];
				f_wd       = f_rd_s1;
				f_wd.mark  = 1'b0;
				f_wd.valid = !age_rm_f;
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			scan_q    <= '0;
			raddr_s1  <= '0;
			rvld_s1   <= 1'b0;
			live_f_q  <= '0;
			live_p_q  <= '0;
			surv_q    <= '0;
			out_vld_q <= 1'b0;
			ff_q      <= 1'b0;
			ffr_q     <= 1'b0;
			ph_q      <= 1'b0;
			pfr_q     <= 1'b0;
		end else begin
			if (pop && out_vld_q) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					scan_q  <= '0;
					rvld_s1 <= 1'b0;
					ff_q    <= 1'b0;
					ffr_q   <= 1'b0;
					ph_q    <= 1'b0;
					pfr_q   <= 1'b0;
					surv_q  <= '0;
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.kind)
							prt_pkg::KIND_LOOKUP: state_q <= ST_FSCAN;
							prt_pkg::KIND_TICK:   state_q <= ST_AGEP;
							default:              state_q <= ST_EMIT;
						endcase
					end
				end
				ST_FSCAN: begin
					rvld_s1  <= f_issue;
					raddr_s1 <= scan_q;
					if (f_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (f_match && !ff_q) begin
						ff_q   <= 1'b1;
						fidx_q <= raddr_s1[FW-1:0];
					end
					if (rvld_s1 && !f_rd_s1.valid && !ffr_q) begin
						ffr_q   <= 1'b1;
						ffree_q <= raddr_s1[FW-1:0];
					end
					if (f_last) begin
						scan_q  <= '0;
						rvld_s1 <= 1'b0;
						state_q <= ST_PSCAN;
					end
				end
				ST_PSCAN: begin
					rvld_s1  <= p_issue;
					raddr_s1 <= scan_q;
					if (p_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (p_match && !ph_q) begin
						ph_q   <= 1'b1;
						pidx_q <= raddr_s1[PW-1:0];
						pcnt_q <= p_rd_s1.cnt;
					end
					if (rvld_s1 && !p_rd_s1.valid && !pfr_q) begin
						pfr_q   <= 1'b1;
						pfree_q <= raddr_s1[PW-1:0];
					end
					if (p_last) begin
						scan_q  <= '0;
						rvld_s1 <= 1'b0;
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (can_emit) begin
						live_f_q  <= live_f_q + FCW'(ins_newf);
						live_p_q  <= live_p_q + PCW'(do_ins);
						out_vld_q <= 1'b1;
						hit_q     <= ph_q;
						cnt_q     <= ph_q ? new_cnt : 16'd0;
						ins_q     <= do_ins;
						full_q    <= drop;
						files_q   <= 8'(live_f_q + FCW'(ins_newf));
						pages_q   <= 11'(live_p_q + PCW'(do_ins));
						state_q   <= ST_IDLE;
					end
				end
				ST_AGEP: begin
					rvld_s1  <= p_issue;
					raddr_s1 <= scan_q;
					if (p_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rvld_s1 && p_rd_s1.valid) begin
						if (p_rd_s1.mark) begin
							surv_q[p_rd_s1.owner] <= 1'b1;
						end else begin
							live_p_q <= live_p_q - 1'b1;
						end
					end
					if (p_last) begin
						scan_q  <= '0;
						rvld_s1 <= 1'b0;
						state_q <= ST_AGEF;
					end
				end
				ST_AGEF: begin
					rvld_s1  <= f_issue;
					raddr_s1 <= scan_q;
					if (f_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (rvld_s1 && f_rd_s1.valid && age_rm_f) begin
						live_f_q <= live_f_q - 1'b1;
					end
					if (f_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (can_emit) begin
						out_vld_q <= 1'b1;
						hit_q     <= 1'b0;
						cnt_q     <= 16'd0;
						ins_q     <= 1'b0;
						full_q    <= 1'b0;
						files_q   <= 8'(live_f_q);
						pages_q   <= 11'(live_p_q);
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result beat
	assign empty         = !out_vld_q;
	assign hit           = hit_q;
	assign refault_count = cnt_q;
	assign inserted      = ins_q;
	assign table_full    = full_q;
	assign files_tracked = files_q;
	assign pages_tracked = pages_q;

	// Checks
	`PRT_ASSERT(a_pages_bound, 1'b1, 32'(live_p_q) <= PAGE_SLOTS, "page count overflow")
	`PRT_ASSERT(a_ins_xor_full, out_vld_q, !(ins_q && full_q), "insert and drop together")
	`PRT_ASSERT(a_hit_clean, out_vld_q && hit_q, !ins_q && !full_q, "hit with insert or drop")
	`PRT_ASSERT_NEXT(a_pop_leaves_idle, cmd_pop, state_q != ST_IDLE, "popped without work")

endmodule

FILE: rtl/page_refault_tracking_table.sv
// Page refault tracking table.
// Input channel: push/full with opcode, file_key, page_offset; a beat is
// taken when push is high and full is low. Result channel: empty/pop; the
// oldest result sits on the result ports while empty is low and leaves on
// pop. Exactly one result per input beat, in order.
// A two-entry command queue sits in front of a sequencer that walks the
// file and page memories one entry per cycle through their single read
// port. A lookup (evict, refault, fault check) runs a dispatch step, a
// file scan, a page scan and an update step. An aging tick runs a page
// sweep then a file sweep. A non-tick item with file key zero skips the
// scans and goes straight to its result.
// After reset a clearing pass invalidates both memories; full stays high
// until it ends.
// If the receiver stalls, the finished result waits in the output register,
// the sequencer holds before writing back, and the queue keeps taking
// beats until it fills.
module page_refault_tracking_table #(
	parameter int FILE_SLOTS = 128,
	parameter int PAGE_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  opcode,
	input  logic [31:0] file_key,
	input  logic [31:0] page_offset,
	output logic        empty,
	input  logic        pop,
	output logic        hit,
	output logic [15:0] refault_count,
	output logic        inserted,
	output logic        table_full,
	output logic [7:0]  files_tracked,
	output logic [10:0] pages_tracked
);

	logic          cmd_valid, cmd_pop, clearing;
	prt_pkg::cmd_t cmd;

	// Front: accept and classify
	prt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.file_key    (file_key),
		.page_offset (page_offset),
		.hold        (clearing),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	// Back: table walk and update
	prt_engine #(
		.FILE_SLOTS (FILE_SLOTS),
		.PAGE_SLOTS (PAGE_SLOTS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd           (cmd),
		.cmd_pop       (cmd_pop),
		.clearing      (clearing),
		.empty         (empty),
		.pop           (pop),
		.hit           (hit),
		.refault_count (refault_count),
		.inserted      (inserted),
		.table_full    (table_full),
		.files_tracked (files_tracked),
		.pages_tracked (pages_tracked)
	);

endmodule
